/* src/i2cms_pkg.sv */
// Shared types and codes for the I2C master bit sequencer.
`default_nettype none

package i2cms_pkg;

    // Sequencer step codes
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] ST_IDLE     = 5'd0;
    localparam logic [STEP_W-1:0] ST_STA_SDA  = 5'd1;
    localparam logic [STEP_W-1:0] ST_STA_SCL  = 5'd2;
    localparam logic [STEP_W-1:0] ST_STA_LOW  = 5'd3;
    localparam logic [STEP_W-1:0] ST_STA_END  = 5'd4;
    localparam logic [STEP_W-1:0] ST_STO_SCL  = 5'd5;
    localparam logic [STEP_W-1:0] ST_STO_SDA  = 5'd6;
    localparam logic [STEP_W-1:0] ST_STO_HIGH = 5'd7;
    localparam logic [STEP_W-1:0] ST_STO_END  = 5'd8;
    localparam logic [STEP_W-1:0] ST_ACK_DRV  = 5'd9;
    localparam logic [STEP_W-1:0] ST_ACK_HIGH = 5'd10;
    localparam logic [STEP_W-1:0] ST_ACK_LOW  = 5'd11;
    localparam logic [STEP_W-1:0] ST_ACK_END  = 5'd12;
    localparam logic [STEP_W-1:0] ST_WR_BIT   = 5'd13;
    localparam logic [STEP_W-1:0] ST_WR_HIGH  = 5'd14;
    localparam logic [STEP_W-1:0] ST_WR_TAIL  = 5'd15;
    localparam logic [STEP_W-1:0] ST_RD_LOW   = 5'd16;
    localparam logic [STEP_W-1:0] ST_RD_HIGH  = 5'd17;
    localparam logic [STEP_W-1:0] ST_RD_TAIL  = 5'd18;
    localparam logic [STEP_W-1:0] ST_WA_HIGH  = 5'd19;
    localparam logic [STEP_W-1:0] ST_WA_LOW   = 5'd20;

    // Command codes
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_ACK   = 3'd4;
    localparam logic [2:0] OP_NACK  = 3'd5;
    localparam logic [2:0] OP_WAIT  = 3'd6;

    // Configuration register indexes and reset values
    localparam logic REG_PHASE_TICKS = 1'b0;
    localparam logic REG_RETRY_LIMIT = 1'b1;
    localparam logic [7:0] PHASE_TICKS_RST = 8'd2;
    localparam logic [7:0] RETRY_LIMIT_RST = 8'd10;

    localparam int BITS_PER_BYTE = 8;
    localparam int TDATA_W       = 16;

    // Input item, cmd_valid in the lowest bit
    typedef struct packed {
        logic       sda_in;
        logic [7:0] wr_data;
        logic [2:0] op;
        logic       cmd_valid;
    } in_item_t;

    // Result item, scl_out in the lowest bit
    typedef struct packed {
        logic       ack_ok;
        logic [7:0] rd_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } res_item_t;

    localparam int IN_W  = $bits(in_item_t);
    localparam int RES_W = $bits(res_item_t);

endpackage

`default_nettype wire

/* src/i2cms_in_reg.sv */
// Input register stage that holds one accepted tick transaction.
`default_nettype none

module i2cms_in_reg
    import i2cms_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [TDATA_W-1:0]   s_tdata,
    input  wire logic                 advance,
    output logic                      item_valid,
    output in_item_t                  item
);

    logic     valid_reg;
    in_item_t item_reg;

    // The stage takes a new transaction when empty or when it hands its item on.
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= in_item_t'(s_tdata[IN_W-1:0]);
        end
    end

endmodule

`default_nettype wire

/* src/i2cms_seq.sv */
// Bus sequencer state, configuration registers and per-tick next-state logic.
`default_nettype none

module i2cms_seq
    import i2cms_pkg::*;
#(
    parameter logic [7:0] PHASE_TICKS_INIT = PHASE_TICKS_RST,
    parameter logic [7:0] RETRY_LIMIT_INIT = RETRY_LIMIT_RST
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        step_en,
    input  wire in_item_t    item,
    output res_item_t        res
);

    logic [7:0]        phase_ticks_reg;
    logic [7:0]        retry_limit_reg;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [2:0]        op_reg, op_next;
    logic [3:0]        bit_cnt_reg, bit_cnt_next;
    logic [7:0]        shift_reg, shift_next;
    logic [7:0]        phase_reg, phase_next;
    logic [7:0]        retry_reg, retry_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              ack_reg, ack_next;
    logic [7:0]        rd_hold_reg, rd_hold_next;

    logic              done;
    logic              enter;
    logic [STEP_W-1:0] enter_step;
    logic [7:0]        phase_len;
    logic [7:0]        phase_dec;

    // A phase length of zero behaves as one tick.
    assign phase_len = (phase_ticks_reg == 8'd0) ? 8'd1 : phase_ticks_reg;
    assign phase_dec = (phase_reg != 8'd0) ? phase_reg - 8'd1 : phase_reg;

    always_comb
    begin
        step_next    = step_reg;
        op_next      = op_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        phase_next   = phase_reg;
        retry_next   = retry_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        ack_next     = ack_reg;
        rd_hold_next = rd_hold_reg;
        done         = 1'b0;
        enter        = 1'b0;
        enter_step   = ST_IDLE;

        if (step_reg != ST_IDLE)
        begin
            phase_next = phase_dec;
            if (phase_dec == 8'd0)
            begin
                unique case (step_reg) inside
                    ST_STA_SDA, ST_STA_SCL, ST_STA_LOW, ST_STO_SCL, ST_STO_SDA,
                    ST_STO_HIGH, ST_ACK_DRV, ST_ACK_HIGH, ST_ACK_LOW:
                    begin
                        enter      = 1'b1;
                        enter_step = step_reg + STEP_W'(1);
                    end
                    ST_WR_BIT:
                    begin
                        enter      = 1'b1;
                        enter_step = ST_WR_HIGH;
                    end
                    ST_WR_HIGH:
                    begin
                        shift_next   = {shift_reg[6:0], 1'b0};
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                        scl_next     = 1'b0;
                        enter        = 1'b1;
                        enter_step   = (bit_cnt_next < 4'(BITS_PER_BYTE)) ? ST_WR_BIT
                                                                          : ST_WR_TAIL;
                    end
                    ST_RD_LOW:
                    begin
                        enter      = 1'b1;
                        enter_step = ST_RD_HIGH;
                    end
                    ST_RD_HIGH:
                    begin
                        shift_next   = {shift_reg[6:0], item.sda_in};
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                        enter        = 1'b1;
                        enter_step   = (bit_cnt_next < 4'(BITS_PER_BYTE)) ? ST_RD_LOW
                                                                          : ST_RD_TAIL;
                    end
                    ST_WA_HIGH:
                    begin
                        if (!item.sda_in)
                        begin
                            ack_next   = 1'b1;
                            enter      = 1'b1;
                            enter_step = ST_WA_LOW;
                        end
                        else if (retry_reg >= retry_limit_reg)
                        begin
                            // Timed out: report no ack and release the bus with a stop.
                            ack_next   = 1'b0;
                            enter      = 1'b1;
                            enter_step = ST_STO_SCL;
                        end
                        else
                        begin
                            retry_next = retry_reg + 8'd1;
                            phase_next = phase_len;
                        end
                    end
                    ST_RD_TAIL:
                    begin
                        rd_hold_next = shift_reg;
                        sda_next     = 1'b1;
                        step_next    = ST_IDLE;
                        done         = 1'b1;
                    end
                    ST_WR_TAIL, ST_WA_LOW:
                    begin
                        sda_next  = 1'b1;
                        step_next = ST_IDLE;
                        done      = 1'b1;
                    end
                    default:
                    begin
                        step_next = ST_IDLE;
                        done      = 1'b1;
                    end
                endcase
            end
        end
        else if (item.cmd_valid && item.op <= OP_WAIT)
        begin
            op_next      = item.op;
            bit_cnt_next = 4'd0;
            retry_next   = 8'd0;
            enter        = 1'b1;
            unique case (item.op)
                OP_START: enter_step = ST_STA_SDA;
                OP_STOP:  enter_step = ST_STO_SCL;
                OP_WRITE:
                begin
                    shift_next = item.wr_data;
                    enter_step = ST_WR_BIT;
                end
                OP_READ:
                begin
                    shift_next = 8'd0;
                    enter_step = ST_RD_LOW;
                end
                OP_WAIT:  enter_step = ST_WA_HIGH;
                default:  enter_step = ST_ACK_DRV;
            endcase
        end

        // Entering a phase loads the phase timer and sets the line levels.
        if (enter)
        begin
            step_next  = enter_step;
            phase_next = phase_len;
            unique case (enter_step) inside
                ST_STA_SDA, ST_STO_END, ST_ACK_END:          sda_next = 1'b1;
                ST_STA_LOW, ST_STO_SDA:                      sda_next = 1'b0;
                ST_STA_SCL, ST_STO_HIGH, ST_ACK_HIGH, ST_WR_HIGH,
                ST_RD_HIGH, ST_WA_HIGH:                      scl_next = 1'b1;
                ST_STA_END, ST_STO_SCL, ST_ACK_LOW, ST_WR_TAIL,
                ST_RD_LOW, ST_RD_TAIL, ST_WA_LOW:            scl_next = 1'b0;
                ST_ACK_DRV:
                begin
                    scl_next = 1'b0;
                    sda_next = (op_next == OP_NACK);
                end
                ST_WR_BIT:                                   sda_next = shift_next[7];
                default:                                     sda_next = sda_next;
            endcase
        end
    end

    assign res.scl_out  = scl_next;
    assign res.sda_out  = sda_next;
    assign res.busy_res = (step_next != ST_IDLE);
    assign res.done_res = done;
    assign res.rd_data  = rd_hold_next;
    assign res.ack_ok   = ack_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_INIT;
            retry_limit_reg <= RETRY_LIMIT_INIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_PHASE_TICKS: phase_ticks_reg <= cfg_wdata;
                REG_RETRY_LIMIT: retry_limit_reg <= cfg_wdata;
                default:         phase_ticks_reg <= phase_ticks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= ST_IDLE;
            op_reg      <= OP_START;
            bit_cnt_reg <= 4'd0;
            shift_reg   <= 8'd0;
            phase_reg   <= 8'd0;
            retry_reg   <= 8'd0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            ack_reg     <= 1'b0;
            rd_hold_reg <= 8'd0;
        end
        else if (step_en)
        begin
            step_reg    <= step_next;
            op_reg      <= op_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
            phase_reg   <= phase_next;
            retry_reg   <= retry_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            ack_reg     <= ack_next;
            rd_hold_reg <= rd_hold_next;
        end
    end

    // A running sequence always has time left in its current phase.
    a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != ST_IDLE) |-> (phase_reg != 8'd0))
        else $error("sequencer busy with an empty phase timer");

    // The bit counter never runs past one byte.
    a_bit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        bit_cnt_reg <= 4'(BITS_PER_BYTE))
        else $error("bit counter past one byte");

    // Completion only comes out of a running sequence and leaves it idle.
    a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && done) |=> (step_reg == ST_IDLE) && ($past(step_reg) != ST_IDLE))
        else $error("completion reported without a running sequence");

    // An idle tick without a command leaves the bus lines alone.
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && step_reg == ST_IDLE && !item.cmd_valid)
        |=> (step_reg == ST_IDLE) && $stable(scl_reg) && $stable(sda_reg))
        else $error("idle tick changed the bus state");

endmodule

`default_nettype wire

/* src/i2c_master_bit_sequencer_unit.sv */
// Top level of the I2C master bit sequencer: input stage, sequencer, result register.
//
// Usage: every transaction on the s_ channel is one time tick of the bus. It carries the
// sampled SDA level and, when cmd_valid is set, a command (start, stop, write byte, read
// byte, send ack, send nack, wait ack). Each tick produces exactly one result transaction
// on the m_ channel with the SCL and SDA drive levels (1 releases the open-drain line),
// busy and done flags, the last received byte and the last wait-ack outcome.
// A command that arrives while a sequence runs, or on its completion tick, is dropped.
// Configuration: phase_ticks (index 0) sets the ticks per bus phase, retry_limit
// (index 1) the extra phases a wait ack holds SCL high before it times out and issues
// a stop. Write them only while no tick is in flight.
// Flow: an accepted tick is held in the input register, processed by the sequencer logic
// and written into the result register, from which its result is offered on the m_ channel.
// Throughput is one tick per cycle while the receiver takes results; the sequencer state
// update for one tick is a single pass of combinational logic.
// Reset: both lines released, sequencer idle, phase_ticks 2, retry_limit 10, received
// byte and ack result zero. When the receiver stalls, the result register holds its
// transaction, the input register fills with one more tick and then s_tready drops.
`default_nettype none

module i2c_master_bit_sequencer_unit
    import i2cms_pkg::*;
#(
    parameter logic [7:0] PHASE_TICKS_INIT = PHASE_TICKS_RST,
    parameter logic [7:0] RETRY_LIMIT_INIT = RETRY_LIMIT_RST
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Configuration write port
    input  wire logic               cfg_we,
    input  wire logic               cfg_addr,
    input  wire logic [7:0]         cfg_wdata,
    // Tick input stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // tdata from bit 0: cmd_valid, op[2:0], wr_data[7:0], sda_in, zero fill
    input  wire logic [TDATA_W-1:0] s_tdata,
    // Result stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // tdata from bit 0: scl_out, sda_out, busy_res, done_res, rd_data[7:0], ack_ok, zero fill
    output logic [TDATA_W-1:0]      m_tdata
);

    logic      item_valid;
    in_item_t  item;
    res_item_t res;
    logic      advance;

    logic      out_valid_reg;
    res_item_t out_res_reg;

    // The sequencer steps whenever a held tick can move into a free result register.
    assign advance = item_valid && (!out_valid_reg || m_tready);

    i2cms_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    i2cms_seq #(
        .PHASE_TICKS_INIT (PHASE_TICKS_INIT),
        .RETRY_LIMIT_INIT (RETRY_LIMIT_INIT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .step_en   (advance),
        .item      (item),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W-RES_W){1'b0}}, out_res_reg};

endmodule

`default_nettype wire

/* tb/tb_i2c_master_bit_sequencer_unit.sv */
// Self-checking stream testbench for the I2C master bit sequencer unit.
`timescale 1ns / 1ps

module tb_i2c_master_bit_sequencer_unit;
    import i2cms_pkg::*;

    // The package names every command except the one code that the block must ignore.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // Cycles with no transaction on either stream before the run is declared hung.
    // The longest legal quiet stretch is one long sender gap plus the pipeline; this leaves a wide margin.
    localparam int HANG_LIMIT = 1000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_addr  = 1'b0;
    logic [7:0]           cfg_wdata = 8'd0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;

    i2c_master_bit_sequencer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 clk = ~clk;

    // Ticks waiting to be sent, and the bus levels expected back, oldest first.
    in_item_t  pending_ticks[$];
    res_item_t bus_levels_q[$];

    int   mismatch_cnt    = 0;
    int   results_checked = 0;
    int   cmds_issued     = 0;
    int   quiet_cycles    = 0;
    logic tx_hold         = 1'b0;
    logic noise_on        = 1'b0;

    // ------------------------------------------------------------------------
    // Sequencer prediction. These variables shadow the block's configuration
    // and its internal state; they advance by one tick per accepted input
    // transaction, in the same order the block sees them.
    // ------------------------------------------------------------------------
    logic [7:0]        phase_ticks_cfg = PHASE_TICKS_RST;
    logic [7:0]        retry_limit_cfg = RETRY_LIMIT_RST;

    logic [STEP_W-1:0] bus_step  = ST_IDLE;
    logic [2:0]        cur_op    = OP_START;
    logic [3:0]        bit_idx   = 4'd0;
    logic [7:0]        shreg     = 8'd0;
    logic [7:0]        step_left = 8'd0;
    logic [7:0]        retries   = 8'd0;
    logic              scl_drv   = 1'b1;
    logic              sda_drv   = 1'b1;
    logic              ack_seen  = 1'b0;
    logic [7:0]        rx_byte   = 8'd0;

    // A programmed phase length of zero behaves like a length of one.
    function automatic logic [7:0] phase_len();
        return (phase_ticks_cfg == 8'd0) ? 8'd1 : phase_ticks_cfg;
    endfunction

    // Enter a bus phase: set the line levels it owns and reload the phase timer.
    function automatic void begin_phase(input logic [STEP_W-1:0] s);
        bus_step  = s;
        step_left = phase_len();
        case (s)
            ST_STA_SDA, ST_STO_END, ST_ACK_END:
                sda_drv = 1'b1;
            ST_STA_LOW, ST_STO_SDA:
                sda_drv = 1'b0;
            ST_STA_SCL, ST_STO_HIGH, ST_ACK_HIGH, ST_WR_HIGH, ST_RD_HIGH, ST_WA_HIGH:
                scl_drv = 1'b1;
            ST_STA_END, ST_STO_SCL, ST_ACK_LOW, ST_WR_TAIL, ST_RD_LOW, ST_RD_TAIL,
            ST_WA_LOW:
                scl_drv = 1'b0;
            ST_ACK_DRV:
            begin
                scl_drv = 1'b0;
                sda_drv = (cur_op == OP_NACK);
            end
            ST_WR_BIT:
                sda_drv = shreg[7];
            default:
                ;
        endcase
    endfunction

    // Advance the shadow sequencer by one tick and return the bus levels and
    // flags that the block must report for that tick.
    function automatic res_item_t i2c_tick_result(input in_item_t it);
        res_item_t r;
        logic      fin;
        fin = 1'b0;
        if (bus_step != ST_IDLE)
        begin
            // Commands are dropped while a sequence runs; only time and SDA matter.
            if (step_left != 8'd0)
                step_left = step_left - 8'd1;
            if (step_left == 8'd0)
            begin
                case (bus_step)
                    ST_STA_SDA, ST_STA_SCL, ST_STA_LOW, ST_STO_SCL, ST_STO_SDA, ST_STO_HIGH,
                    ST_ACK_DRV, ST_ACK_HIGH, ST_ACK_LOW:
                        begin_phase(bus_step + 1'b1);
                    ST_WR_BIT:
                        begin_phase(ST_WR_HIGH);
                    ST_WR_HIGH:
                    begin
                        // SCL falls at once when a bit has been clocked out.
                        shreg   = shreg << 1;
                        bit_idx = bit_idx + 4'd1;
                        scl_drv = 1'b0;
                        begin_phase((bit_idx < BITS_PER_BYTE) ? ST_WR_BIT : ST_WR_TAIL);
                    end
                    ST_RD_LOW:
                        begin_phase(ST_RD_HIGH);
                    ST_RD_HIGH:
                    begin
                        shreg   = {shreg[6:0], it.sda_in};
                        bit_idx = bit_idx + 4'd1;
                        begin_phase((bit_idx < BITS_PER_BYTE) ? ST_RD_LOW : ST_RD_TAIL);
                    end
                    ST_WA_HIGH:
                    begin
                        if (!it.sda_in)
                        begin
                            ack_seen = 1'b1;
                            begin_phase(ST_WA_LOW);
                        end
                        else if (retries >= retry_limit_cfg)
                        begin
                            // Timed out: report no ack now and close the bus with a stop.
                            ack_seen = 1'b0;
                            begin_phase(ST_STO_SCL);
                        end
                        else
                        begin
                            retries   = retries + 8'd1;
                            step_left = phase_len();
                        end
                    end
                    ST_RD_TAIL:
                    begin
                        rx_byte = shreg;
                        sda_drv = 1'b1;
                        fin     = 1'b1;
                    end
                    ST_WR_TAIL, ST_WA_LOW:
                    begin
                        sda_drv = 1'b1;
                        fin     = 1'b1;
                    end
                    default:
                        fin = 1'b1;
                endcase
                if (fin)
                    bus_step = ST_IDLE;
            end
        end
        else if (it.cmd_valid && it.op != OP_UNUSED)
        begin
            cur_op  = it.op;
            bit_idx = 4'd0;
            retries = 8'd0;
            case (it.op)
                OP_START:
                    begin_phase(ST_STA_SDA);
                OP_STOP:
                    begin_phase(ST_STO_SCL);
                OP_WRITE:
                begin
                    shreg = it.wr_data;
                    begin_phase(ST_WR_BIT);
                end
                OP_READ:
                begin
                    shreg = 8'd0;
                    begin_phase(ST_RD_LOW);
                end
                OP_WAIT:
                    begin_phase(ST_WA_HIGH);
                default:
                    begin_phase(ST_ACK_DRV);
            endcase
        end
        r.scl_out  = scl_drv;
        r.sda_out  = sda_drv;
        r.busy_res = (bus_step != ST_IDLE);
        r.done_res = fin;
        r.rd_data  = rx_byte;
        r.ack_ok   = ack_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Idle pattern shared by both stream sides: mostly back to back, some short
    // gaps, a few long ones, and now and then a long run with no gaps at all.
    // ------------------------------------------------------------------------
    function automatic int pick_idle(inout int burst);
        int r;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            burst = $urandom_range(40, 160);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Takes ticks from the pending queue, keeps tvalid up until the
    // transaction is taken, and runs the predictor on every accepted tick.
    // ------------------------------------------------------------------------
    int tx_gap   = 0;
    int tx_burst = 0;

    always @(posedge clk or negedge rst_n)
    begin : feed_ticks
        in_item_t nxt;
        logic     load;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                bus_levels_q.push_back(i2c_tick_result(in_item_t'(s_tdata[IN_W-1:0])));
            if (!s_tvalid || s_tready)
            begin
                load = 1'b0;
                if (tx_gap != 0)
                    tx_gap--;
                else if (!tx_hold && pending_ticks.size() != 0)
                begin
                    nxt     = pending_ticks.pop_front();
                    s_tdata <= {{(TDATA_W - IN_W){1'b0}}, nxt};
                    load    = 1'b1;
                    tx_gap  = pick_idle(tx_burst);
                end
                s_tvalid <= load;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Stalls tready at random and compares every result transaction
    // with the oldest expected bus levels, field by field.
    // ------------------------------------------------------------------------
    int rx_stall = 0;
    int rx_burst = 0;

    always @(posedge clk or negedge rst_n)
    begin : check_levels
        res_item_t got;
        res_item_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = res_item_t'(m_tdata[RES_W-1:0]);
                results_checked++;
                if (bus_levels_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("result %0d arrived with nothing expected: %h",
                                 results_checked, got);
                end
                else
                begin
                    want = bus_levels_q.pop_front();
                    if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
                        got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
                        got.rd_data !== want.rd_data || got.ack_ok !== want.ack_ok)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"result %0d expected/actual: scl %b/%b sda %b/%b ",
                                      "busy %b/%b done %b/%b rd_data %h/%h ack %b/%b"},
                                     results_checked, want.scl_out, got.scl_out,
                                     want.sda_out, got.sda_out, want.busy_res, got.busy_res,
                                     want.done_res, got.done_res, want.rd_data, got.rd_data,
                                     want.ack_ok, got.ack_ok);
                    end
                end
            end
            if (rx_stall != 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                rx_stall = pick_idle(rx_burst);
            end
        end
    end

    // Hang detection: any stretch that long with no transaction means the block stopped.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Queue one command tick followed by enough plain ticks to cover the bus
    // sequence it starts, plus `tail` more. A negative tail makes the next
    // command land while the sequence still runs (or, at -1, on its completion
    // tick), which the block must drop. For a wait ack, SDA stays high until the
    // end of phase `ack_at` and is pulled low there; past the retry limit the
    // wait times out. Other commands see SDA fixed at sda_fill, or random if < 0.
    task automatic run_cmd(input logic [2:0] op, input logic [7:0] data, input int ack_at,
                           input int sda_fill, input int tail);
        int       p;
        int       dur;
        int       span;
        in_item_t it;
        p = phase_len();
        case (op)
            OP_WRITE, OP_READ:
                dur = (2 * BITS_PER_BYTE + 1) * p;
            OP_WAIT:
                dur = (ack_at <= retry_limit_cfg) ? (ack_at + 2) * p
                                                  : (retry_limit_cfg + 5) * p;
            OP_UNUSED:
                dur = 0;
            default:
                dur = 4 * p;
        endcase
        span = dur + tail;
        if (span < 0)
            span = 0;
        for (int t = 0; t <= span; t++)
        begin
            it.cmd_valid = (t == 0);
            it.op        = (t == 0) ? op : 3'($urandom);
            it.wr_data   = (t == 0) ? data : 8'($urandom);
            // Stray commands in the middle of a sequence must be ignored.
            if (noise_on && t > 0 && t < dur && $urandom_range(0, 24) == 0)
                it.cmd_valid = 1'b1;
            if (op == OP_WAIT && t > 0 && t <= (ack_at + 1) * p)
                it.sda_in = (t != (ack_at + 1) * p);
            else if (sda_fill >= 0)
                it.sda_in = sda_fill[0];
            else
                it.sda_in = 1'($urandom);
            pending_ticks.push_back(it);
        end
        cmds_issued++;
    endtask

    function automatic int pick_tail();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 3);
        if (r < 80)
            return -1;
        if (r < 85)
            return -int'($urandom_range(2, 6));
        return $urandom_range(4, 12);
    endfunction

    // Phase at which the slave acks; one past the retry limit means no ack at all.
    function automatic int pick_ack();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, (retry_limit_cfg < 3) ? retry_limit_cfg : 3);
        if (r < 85)
            return $urandom_range(0, retry_limit_cfg);
        return retry_limit_cfg + 1;
    endfunction

    // Random I2C frames: start, address byte, ack check, a few data bytes read
    // or written with their acks, stop, and now and then a stray command.
    task automatic random_frames(input int n);
        int   stop_at;
        int   nbytes;
        logic rd;
        stop_at = cmds_issued + n;
        while (cmds_issued < stop_at)
        begin
            run_cmd(OP_START, 8'($urandom), 0, -1, pick_tail());
            run_cmd(OP_WRITE, 8'($urandom), 0, -1, pick_tail());
            run_cmd(OP_WAIT, 8'($urandom), pick_ack(), -1, pick_tail());
            nbytes = $urandom_range(1, 3);
            rd     = 1'($urandom);
            for (int k = 0; k < nbytes; k++)
            begin
                if (rd)
                begin
                    run_cmd(OP_READ, 8'($urandom), 0, -1, pick_tail());
                    run_cmd((k == nbytes - 1) ? OP_NACK : OP_ACK, 8'($urandom), 0, -1,
                            pick_tail());
                end
                else
                begin
                    run_cmd(OP_WRITE, 8'($urandom), 0, -1, pick_tail());
                    run_cmd(OP_WAIT, 8'($urandom), pick_ack(), -1, pick_tail());
                end
            end
            run_cmd(OP_STOP, 8'($urandom), 0, -1, pick_tail());
            if ($urandom_range(0, 7) == 0)
                run_cmd(3'($urandom), 8'($urandom), pick_ack(), -1, pick_tail());
        end
    endtask

    // Wait until every queued tick has been sent and every result checked,
    // then give the two-stage pipeline time to settle.
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || s_tvalid || bus_levels_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Bring the sequencer itself to idle before the configuration changes.
    task automatic settle();
        in_item_t it;
        wait_drained();
        while (bus_step != ST_IDLE)
        begin
            for (int k = 0; k < 16; k++)
            begin
                it           = in_item_t'($urandom);
                it.cmd_valid = 1'b0;
                pending_ticks.push_back(it);
            end
            wait_drained();
        end
    endtask

    task automatic set_regs(input logic [7:0] ticks, input logic [7:0] retry);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_PHASE_TICKS;
        cfg_wdata <= ticks;
        @(posedge clk);
        cfg_addr  <= REG_RETRY_LIMIT;
        cfg_wdata <= retry;
        @(posedge clk);
        cfg_we    <= 1'b0;
        phase_ticks_cfg = ticks;
        retry_limit_cfg = retry;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin : run_test
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset configuration: two ticks per phase, ten retries.
        run_cmd(OP_UNUSED, 8'hFF, 0, -1, 2);                    // unknown op stays idle
        run_cmd(OP_START, 8'h00, 0, -1, 1);
        run_cmd(OP_WRITE, 8'hFF, 0, -1, 1);
        run_cmd(OP_WAIT, 8'h00, 0, -1, 1);                      // ack on the first phase
        run_cmd(OP_WRITE, 8'h00, 0, -1, 0);
        run_cmd(OP_WAIT, 8'h00, retry_limit_cfg, -1, 1);        // ack on the last retry
        run_cmd(OP_READ, 8'h00, 0, 1, 1);                       // all ones
        run_cmd(OP_ACK, 8'h00, 0, -1, 1);
        run_cmd(OP_READ, 8'hFF, 0, 0, 1);                       // all zeros
        run_cmd(OP_NACK, 8'h00, 0, -1, 1);
        run_cmd(OP_WAIT, 8'h00, retry_limit_cfg + 1, -1, 1);    // timeout, then stop
        run_cmd(OP_START, 8'h00, 0, -1, -1);                    // next one on completion
        run_cmd(OP_STOP, 8'h00, 0, -1, 1);
        run_cmd(OP_WRITE, 8'hA5, 0, -1, -3);                    // next one while busy
        run_cmd(OP_READ, 8'h5A, 0, -1, 1);
        run_cmd(OP_WRITE, 8'h5A, 0, -1, 1);
        run_cmd(OP_STOP, 8'h00, 0, -1, 1);

        noise_on = 1'b1;
        random_frames(8);

        // Shortest phase and no retries at all.
        settle();
        set_regs(8'd1, 8'd0);
        random_frames(24);

        // A zero phase length must behave like one tick.
        settle();
        set_regs(8'd0, 8'd3);
        random_frames(16);

        // Longer phases and a wider retry window, with the sender held off halfway
        // until the receiver has caught up with everything in flight.
        settle();
        set_regs(8'd3, 8'd20);
        random_frames(8);
        while (pending_ticks.size() > 40)
            @(posedge clk);
        tx_hold <= 1'b1;
        @(posedge clk);
        while (s_tvalid || bus_levels_q.size() != 0)
            @(posedge clk);
        tx_hold <= 1'b0;
        random_frames(8);

        wait_drained();
        if (mismatch_cnt == 0 && bus_levels_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
